### src/rsch_pkg.sv
package rsch_pkg;

  // Packet layout
  localparam int HEADER_BYTES = 6;
  localparam int RESP_BYTES   = 10;
  localparam int SET_MIN_SIZE = 4;

  // Command codes
  localparam logic [7:0] CMD_GET      = 8'h01;
  localparam logic [7:0] CMD_SET      = 8'h02;
  localparam logic [7:0] CMD_RESPONSE = 8'hF1;
  localparam logic [7:0] RESP_SIZE    = 8'h04;

  // Configuration register indexes and reset values
  localparam logic [1:0]  REG_DEVICE_ID   = 2'd0;
  localparam logic [1:0]  REG_LISTEN_PIPE = 2'd1;
  localparam logic [31:0] DEVICE_ID_RESET   = 32'h0001_5566;
  localparam logic [2:0]  LISTEN_PIPE_RESET = 3'd1;

  // Response queue between front and back
  localparam int QUEUE_DEPTH = 2;

  typedef logic [3:0] resp_idx_t;

  typedef struct packed {
    logic [31:0] device_id;
    logic [2:0]  listen_pipe;
  } cfg_t;

  // One pending response: id and state to report, save flag
  typedef struct packed {
    logic [31:0] device_id;
    logic [31:0] state;
    logic        save;
  } resp_t;

endpackage

### src/rsch_front.sv
module rsch_front import rsch_pkg::*; #(
  parameter int RX_BUFFER_BYTES = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  logic       rx_valid_i,
  output logic       rx_ready_o,
  input  logic [2:0] pipe_number_i,
  input  logic [7:0] rx_byte_i,
  input  logic       rx_last_i,
  input  logic       q_full_i,
  output logic       q_push_o,
  output resp_t      q_data_o
);

  localparam int CntW = $clog2(RX_BUFFER_BYTES + 1);

  logic [CntW-1:0] byte_count_q, byte_count_d, length_d, pl_idx;
  logic [31:0]     header_id_q, header_id_d;
  logic [7:0]      header_cmd_q, header_cmd_d;
  logic [7:0]      header_size_q, header_size_d;
  logic [31:0]     payload_q, payload_d;
  logic            overflow_q, overflow_d;
  logic [31:0]     state_q, state_d;
  logic            fire, room, ok, is_get, is_set;

  assign rx_ready_o = !q_full_i;
  assign fire       = rx_valid_i && rx_ready_o;
  assign room       = byte_count_q < CntW'(RX_BUFFER_BYTES);
  assign pl_idx     = byte_count_q - CntW'(HEADER_BYTES);

  // Header fields and payload word as they stand once the current byte is stored
  always_comb begin
    header_id_d   = header_id_q;
    header_cmd_d  = header_cmd_q;
    header_size_d = header_size_q;
    payload_d     = payload_q;
    if (room) begin
      if (byte_count_q < CntW'(4)) begin
        header_id_d[{byte_count_q[1:0], 3'b000} +: 8] = rx_byte_i;
      end else if (byte_count_q == CntW'(4)) begin
        header_cmd_d = rx_byte_i;
      end else if (byte_count_q == CntW'(5)) begin
        header_size_d = rx_byte_i;
      end else if (byte_count_q < CntW'(HEADER_BYTES + 4)) begin
        payload_d[{pl_idx[1:0], 3'b000} +: 8] = rx_byte_i;
      end
    end
  end

  assign length_d   = room ? byte_count_q + CntW'(1) : byte_count_q;
  assign overflow_d = overflow_q || !room;

  assign ok = !overflow_d
           && (pipe_number_i == cfg_i.listen_pipe)
           && (length_d >= CntW'(HEADER_BYTES))
           && (header_id_d == cfg_i.device_id)
           && (9'(HEADER_BYTES) + {1'b0, header_size_d} == 9'(length_d));

  assign is_get = header_cmd_d == CMD_GET;
  assign is_set = (header_cmd_d == CMD_SET) && (header_size_d >= 8'(SET_MIN_SIZE));

  assign q_push_o           = fire && rx_last_i && ok && (is_get || is_set);
  assign state_d            = (q_push_o && is_set) ? payload_d : state_q;
  assign q_data_o.device_id = cfg_i.device_id;
  assign q_data_o.state     = state_d;
  assign q_data_o.save      = is_set && (state_q != payload_d);

  // End of packet clears the count and overflow mark, accepted or not
  assign byte_count_d = rx_last_i ? '0 : length_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_count_q  <= '0;
      overflow_q    <= 1'b0;
      header_id_q   <= '0;
      header_cmd_q  <= '0;
      header_size_q <= '0;
      payload_q     <= '0;
      state_q       <= '0;
    end else if (fire) begin
      byte_count_q  <= byte_count_d;
      overflow_q    <= rx_last_i ? 1'b0 : overflow_d;
      header_id_q   <= header_id_d;
      header_cmd_q  <= header_cmd_d;
      header_size_q <= header_size_d;
      payload_q     <= payload_d;
      state_q       <= state_d;
    end
  end

endmodule

### src/rsch_queue.sv
module rsch_queue import rsch_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  resp_t data_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  valid_o,
  output resp_t data_o
);

  localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CntW = $clog2(QUEUE_DEPTH + 1);

  resp_t           entry_q [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;

  assign full_o  = count_q == CntW'(QUEUE_DEPTH);
  assign valid_o = count_q != '0;
  assign data_o  = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

endmodule

### src/rsch_back.sv
module rsch_back import rsch_pkg::*; #(
  parameter int OUTPUT_COUNT = 7
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       q_valid_i,
  input  resp_t      q_data_i,
  output logic       q_pop_o,
  output logic       tx_valid_o,
  input  logic       tx_ready_i,
  output logic [7:0] tx_byte_o,
  output logic       tx_last_o,
  output logic [6:0] switch_outputs_o,
  output logic       save_request_o
);

  localparam resp_idx_t LastIdx = resp_idx_t'(RESP_BYTES - 1);

  resp_t     resp_q;
  resp_idx_t idx_q, st_idx;
  logic      active_q, fire;

  assign fire    = active_q && tx_ready_i;
  assign q_pop_o = q_valid_i && (!active_q || (fire && tx_last_o));
  assign st_idx  = idx_q - resp_idx_t'(HEADER_BYTES);

  assign tx_valid_o     = active_q;
  assign tx_last_o      = idx_q == LastIdx;
  assign save_request_o = (idx_q == '0) && resp_q.save;

  always_comb begin
    case (idx_q)
      4'd0, 4'd1, 4'd2, 4'd3: tx_byte_o = resp_q.device_id[{idx_q[1:0], 3'b000} +: 8];
      4'd4:                   tx_byte_o = CMD_RESPONSE;
      4'd5:                   tx_byte_o = RESP_SIZE;
      default:                tx_byte_o = resp_q.state[{st_idx[1:0], 3'b000} +: 8];
    endcase
  end

  // Output i mirrors state bit 7-i
  always_comb begin
    switch_outputs_o = '0;
    for (int i = 0; i < 7; i++) begin
      if (i < OUTPUT_COUNT) begin
        switch_outputs_o[i] = resp_q.state[7 - i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      resp_q <= q_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      idx_q    <= '0;
    end else if (q_pop_o) begin
      active_q <= 1'b1;
      idx_q    <= '0;
    end else if (fire) begin
      if (tx_last_o) begin
        active_q <= 1'b0;
      end
      idx_q <= idx_q + resp_idx_t'(1);
    end
  end

endmodule

### src/radio_switch_command_handler_top.sv
// Channel   Handshake                 Payload
// rx        rx_valid_i / rx_ready_o   pipe_number_i, rx_byte_i, rx_last_i
// tx        tx_valid_o / tx_ready_i   tx_byte_o, tx_last_o, switch_outputs_o, save_request_o
// cfg       cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// One received byte is taken per cycle; the packet check is made in the cycle of the
// final byte. Each accepted GET or SET queues one response that leaves as 10 tx bytes,
// one per cycle while tx_ready_i is high. rx stalls only while the two-entry response
// queue is full, so the tx drain rate sets the sustained packet rate under load.
// Reset clears the byte count, header, switch state, queue and the tx side, and
// loads the register defaults.
module radio_switch_command_handler_top import rsch_pkg::*; #(
  parameter int RX_BUFFER_BYTES = 32,
  parameter int OUTPUT_COUNT    = 7
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  // received bytes
  input  logic        rx_valid_i,
  output logic        rx_ready_o,
  input  logic [2:0]  pipe_number_i,
  input  logic [7:0]  rx_byte_i,
  input  logic        rx_last_i,
  // response bytes
  output logic        tx_valid_o,
  input  logic        tx_ready_i,
  output logic [7:0]  tx_byte_o,
  output logic        tx_last_o,
  output logic [6:0]  switch_outputs_o,
  output logic        save_request_o
);

  cfg_t  cfg_q;
  logic  q_push, q_full, q_pop, q_valid;
  resp_t q_wdata, q_rdata;

  // Register writes are always taken; unknown indexes are dropped
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.device_id   <= DEVICE_ID_RESET;
      cfg_q.listen_pipe <= LISTEN_PIPE_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_DEVICE_ID:   cfg_q.device_id   <= cfg_data_i;
        REG_LISTEN_PIPE: cfg_q.listen_pipe <= cfg_data_i[2:0];
        default: ;
      endcase
    end
  end

  // Front: collect the header, check the packet, apply SET, queue the response
  rsch_front #(
    .RX_BUFFER_BYTES(RX_BUFFER_BYTES)
  ) u_front (
    .clk_i,
    .rst_ni,
    .cfg_i        (cfg_q),
    .rx_valid_i,
    .rx_ready_o,
    .pipe_number_i,
    .rx_byte_i,
    .rx_last_i,
    .q_full_i     (q_full),
    .q_push_o     (q_push),
    .q_data_o     (q_wdata)
  );

  // Hold pending responses so each side stalls on its own
  rsch_queue u_queue (
    .clk_i,
    .rst_ni,
    .push_i  (q_push),
    .data_i  (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (q_rdata)
  );

  // Back: serialize each response into 10 tx transfers
  rsch_back #(
    .OUTPUT_COUNT(OUTPUT_COUNT)
  ) u_back (
    .clk_i,
    .rst_ni,
    .q_valid_i (q_valid),
    .q_data_i  (q_rdata),
    .q_pop_o   (q_pop),
    .tx_valid_o,
    .tx_ready_i,
    .tx_byte_o,
    .tx_last_o,
    .switch_outputs_o,
    .save_request_o
  );

endmodule

### sim/radio_switch_command_handler_tb.sv
`timescale 1ns / 1ps

module testbench import rsch_pkg::*;;

  localparam int RX_BUFFER_BYTES = 32;
  localparam int OUTPUT_COUNT    = 7;
  localparam int CYCLE_LIMIT     = 300000;
  // Cycles to let the block settle after the last response before a register write
  localparam int SETTLE_CYCLES   = 24;
  localparam int PHASE_COUNT     = 4;
  localparam int BYTES_PER_PHASE = 90;

  // One expected response byte on the tx channel
  typedef struct {
    logic [7:0] tx_byte;
    logic       tx_last;
    logic [6:0] switch_outputs;
    logic       save_request;
  } tx_beat_t;

  typedef enum int {
    PK_GET, PK_SET, PK_SET_SAME, PK_SET_SHORT, PK_UNKNOWN_CMD, PK_BAD_ID,
    PK_BAD_PIPE, PK_BAD_LENGTH, PK_OVERSIZE, PK_RUNT, PK_NOISE
  } pkt_kind_e;

  // Predicts the handler byte by byte and holds the response bytes still owed.
  class switch_scoreboard;
    logic [31:0] device_id;
    logic [2:0]  listen_pipe;
    logic [5:0]  byte_count;
    logic [31:0] hdr_id;
    logic [7:0]  hdr_cmd;
    logic [7:0]  hdr_size;
    logic [31:0] payload_word;
    logic        overflow;
    logic [31:0] switch_state;
    tx_beat_t    pending_tx[$];
    int          fails;

    function new();
      device_id    = DEVICE_ID_RESET;
      listen_pipe  = LISTEN_PIPE_RESET;
      byte_count   = '0;
      hdr_id       = '0;
      hdr_cmd      = '0;
      hdr_size     = '0;
      payload_word = '0;
      overflow     = 1'b0;
      switch_state = '0;
      fails        = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [31:0] data);
      case (idx)
        REG_DEVICE_ID:   device_id = data;
        REG_LISTEN_PIPE: listen_pipe = data[2:0];
        default: ;
      endcase
    endfunction

    function void queue_response(logic save);
      logic [7:0] resp[RESP_BYTES];
      logic [6:0] outs;
      tx_beat_t   beat;
      outs = '0;
      for (int i = 0; i < OUTPUT_COUNT && i < 7; i++) outs[i] = switch_state[7 - i];
      for (int k = 0; k < 4; k++) begin
        resp[k]     = device_id[8*k +: 8];
        resp[6 + k] = switch_state[8*k +: 8];
      end
      resp[4] = CMD_RESPONSE;
      resp[5] = RESP_SIZE;
      for (int k = 0; k < RESP_BYTES; k++) begin
        beat.tx_byte        = resp[k];
        beat.tx_last        = (k == RESP_BYTES - 1);
        beat.switch_outputs = outs;
        beat.save_request   = (k == 0) && save;
        pending_tx.push_back(beat);
      end
    endfunction

    function void note_rx(logic [2:0] pipe, logic [7:0] data, logic last);
      logic ok;
      logic changed;
      if (byte_count < RX_BUFFER_BYTES) begin
        if (byte_count < 4) hdr_id[8*byte_count +: 8] = data;
        else if (byte_count == 4) hdr_cmd = data;
        else if (byte_count == 5) hdr_size = data;
        else if (byte_count < 10) payload_word[8*(byte_count - 6) +: 8] = data;
        byte_count++;
      end else begin
        overflow = 1'b1;
      end
      if (!last) return;
      ok = !overflow && pipe == listen_pipe && byte_count >= HEADER_BYTES
           && hdr_id == device_id && HEADER_BYTES + hdr_size == byte_count;
      byte_count = '0;
      overflow   = 1'b0;
      if (!ok) return;
      if (hdr_cmd == CMD_GET) begin
        queue_response(1'b0);
      end else if (hdr_cmd == CMD_SET && hdr_size >= SET_MIN_SIZE) begin
        changed      = switch_state != payload_word;
        switch_state = payload_word;
        queue_response(changed);
      end
    endfunction

    function void check_tx(logic [7:0] b, logic last, logic [6:0] outs, logic save);
      tx_beat_t exp_beat;
      if (pending_tx.size() == 0) begin
        $error("tx transfer with no response pending: tx_byte %0h", b);
        fails++;
        return;
      end
      exp_beat = pending_tx.pop_front();
      if (b !== exp_beat.tx_byte) begin
        $error("tx_byte: expected %0h, got %0h", exp_beat.tx_byte, b);
        fails++;
      end
      if (last !== exp_beat.tx_last) begin
        $error("tx_last: expected %0h, got %0h", exp_beat.tx_last, last);
        fails++;
      end
      if (outs !== exp_beat.switch_outputs) begin
        $error("switch_outputs: expected %0h, got %0h", exp_beat.switch_outputs, outs);
        fails++;
      end
      if (save !== exp_beat.save_request) begin
        $error("save_request: expected %0h, got %0h", exp_beat.save_request, save);
        fails++;
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni        = 1'b0;
  logic        cfg_valid_i   = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i   = '0;
  logic [31:0] cfg_data_i    = '0;
  logic        rx_valid_i    = 1'b0;
  logic        rx_ready_o;
  logic [2:0]  pipe_number_i = '0;
  logic [7:0]  rx_byte_i     = '0;
  logic        rx_last_i     = 1'b0;
  logic        tx_valid_o;
  logic        tx_ready_i    = 1'b0;
  logic [7:0]  tx_byte_o;
  logic        tx_last_o;
  logic [6:0]  switch_outputs_o;
  logic        save_request_o;

  switch_scoreboard sb = new();

  // Idle pressure in percent (per byte on rx, per cycle on tx); zero turns bursts off on that side
  int          rx_gap_pct   = 0;
  int          tx_stall_pct = 0;
  int          tx_hold_left = 0;
  int          cycle_count  = 0;
  int          bytes_sent   = 0;

  // Packet under construction and the pipe its final byte goes out on
  logic [7:0]  pkt_bytes[$];
  logic [2:0]  pkt_pipe;

  radio_switch_command_handler_top #(
    .RX_BUFFER_BYTES(RX_BUFFER_BYTES),
    .OUTPUT_COUNT   (OUTPUT_COUNT)
  ) DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .rx_valid_i      (rx_valid_i),
    .rx_ready_o      (rx_ready_o),
    .pipe_number_i   (pipe_number_i),
    .rx_byte_i       (rx_byte_i),
    .rx_last_i       (rx_last_i),
    .tx_valid_o      (tx_valid_o),
    .tx_ready_i      (tx_ready_i),
    .tx_byte_o       (tx_byte_o),
    .tx_last_o       (tx_last_o),
    .switch_outputs_o(switch_outputs_o),
    .save_request_o  (save_request_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Monitors: sample the handshakes at the edge, before this edge's updates land.
  always @(posedge clk_i) begin
    if (rst_ni && cfg_valid_i && cfg_ready_o) sb.write_reg(cfg_index_i, cfg_data_i);
    if (rst_ni && rx_valid_i && rx_ready_o) sb.note_rx(pipe_number_i, rx_byte_i, rx_last_i);
    if (rst_ni && tx_valid_o && tx_ready_i)
      sb.check_tx(tx_byte_o, tx_last_o, switch_outputs_o, save_request_o);
  end

  // Receiver side: drop ready in bursts at random.
  always @(posedge clk_i) begin
    if (tx_hold_left > 0) begin
      tx_hold_left <= tx_hold_left - 1;
    end else if ($urandom_range(0, 99) < tx_stall_pct) begin
      tx_ready_i   <= 1'b0;
      tx_hold_left <= $urandom_range(0, 15);
    end else begin
      tx_ready_i <= 1'b1;
    end
  end

  // Watchdog: end the run if the block hangs.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("radio_switch_command_handler_top regression: fail");
      $finish;
    end
  end

  // Present one received byte, possibly after an idle burst, and hold it until the
  // transfer. Valid stays high on return so back-to-back bytes keep streaming.
  task automatic send_rx_byte(input logic [2:0] pipe, input logic [7:0] data,
                              input logic last);
    int gap;
    if ($urandom_range(0, 99) < rx_gap_pct) begin
      gap = $urandom_range(1, 16);
      rx_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    rx_valid_i    <= 1'b1;
    pipe_number_i <= pipe;
    rx_byte_i     <= data;
    rx_last_i     <= last;
    do @(posedge clk_i); while (!rx_ready_o);
    bytes_sent++;
  endtask

  // Stream the built packet; only the final byte's pipe is checked, so scatter the rest.
  task automatic send_packet();
    int n;
    n = pkt_bytes.size();
    for (int i = 0; i < n; i++) begin
      if (i == n - 1) send_rx_byte(pkt_pipe, pkt_bytes[i], 1'b1);
      else            send_rx_byte(3'($urandom_range(0, 5)), pkt_bytes[i], 1'b0);
    end
  endtask

  task automatic start_packet(input logic [31:0] id, input logic [7:0] cmd,
                              input logic [7:0] size);
    pkt_bytes.delete();
    for (int k = 0; k < 4; k++) pkt_bytes.push_back(id[8*k +: 8]);
    pkt_bytes.push_back(cmd);
    pkt_bytes.push_back(size);
  endtask

  // Append payload bytes; the first four carry the switch word, little endian.
  task automatic add_payload(input int count, input logic [31:0] word);
    for (int k = 0; k < count; k++)
      pkt_bytes.push_back(k < 4 ? word[8*k +: 8] : 8'($urandom));
  endtask

  // Build one random packet: mostly well-formed commands, the rest broken on purpose.
  task automatic make_random_packet();
    int        pick;
    int        size;
    int        n;
    logic [7:0] cmd;
    pkt_kind_e kind;
    pick = $urandom_range(0, 99);
    if      (pick < 22) kind = PK_GET;
    else if (pick < 44) kind = PK_SET;
    else if (pick < 50) kind = PK_SET_SAME;
    else if (pick < 56) kind = PK_SET_SHORT;
    else if (pick < 62) kind = PK_UNKNOWN_CMD;
    else if (pick < 70) kind = PK_BAD_ID;
    else if (pick < 78) kind = PK_BAD_PIPE;
    else if (pick < 85) kind = PK_BAD_LENGTH;
    else if (pick < 90) kind = PK_OVERSIZE;
    else if (pick < 95) kind = PK_RUNT;
    else                kind = PK_NOISE;
    pkt_pipe = sb.listen_pipe;
    cmd = $urandom_range(0, 1) ? CMD_GET : CMD_SET;
    case (kind)
      PK_GET: begin
        size = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 26) : 0;
        start_packet(sb.device_id, CMD_GET, 8'(size));
        add_payload(size, $urandom);
      end
      PK_SET: begin
        size = ($urandom_range(0, 2) == 0) ? $urandom_range(5, 26) : 4;
        start_packet(sb.device_id, CMD_SET, 8'(size));
        add_payload(size, $urandom);
      end
      PK_SET_SAME: begin
        start_packet(sb.device_id, CMD_SET, 8'(SET_MIN_SIZE));
        add_payload(SET_MIN_SIZE, sb.switch_state);
      end
      PK_SET_SHORT: begin
        size = $urandom_range(0, SET_MIN_SIZE - 1);
        start_packet(sb.device_id, CMD_SET, 8'(size));
        add_payload(size, $urandom);
      end
      PK_UNKNOWN_CMD: begin
        do cmd = 8'($urandom); while (cmd == CMD_GET || cmd == CMD_SET);
        size = $urandom_range(0, 8);
        start_packet(sb.device_id, cmd, 8'(size));
        add_payload(size, $urandom);
      end
      PK_BAD_ID: begin
        start_packet(sb.device_id ^ (32'd1 << $urandom_range(0, 31)), cmd, 8'd4);
        add_payload(4, $urandom);
      end
      PK_BAD_PIPE: begin
        start_packet(sb.device_id, CMD_GET, 8'd0);
        do pkt_pipe = 3'($urandom_range(0, 5)); while (pkt_pipe == sb.listen_pipe);
      end
      PK_BAD_LENGTH: begin
        size = $urandom_range(0, 10);
        do n = $urandom_range(0, 12); while (n == size);
        start_packet(sb.device_id, cmd, 8'(size));
        add_payload(n, $urandom);
      end
      PK_OVERSIZE: begin
        // header and size agree with the length; only the buffer limit rejects it
        size = $urandom_range(RX_BUFFER_BYTES + 1, RX_BUFFER_BYTES + 8) - HEADER_BYTES;
        start_packet(sb.device_id, cmd, 8'(size));
        add_payload(size, $urandom);
      end
      PK_RUNT: begin
        start_packet(sb.device_id, cmd, 8'd0);
        n = $urandom_range(1, HEADER_BYTES - 1);
        while (pkt_bytes.size() > n) void'(pkt_bytes.pop_back());
      end
      default: begin
        pkt_bytes.delete();
        n = $urandom_range(1, 40);
        repeat (n) pkt_bytes.push_back(8'($urandom));
        pkt_pipe = 3'($urandom_range(0, 5));
      end
    endcase
  endtask

  // Drop rx valid, wait for every owed response byte, then let the block go quiet.
  // Step one edge first so the monitor has noted the final byte's transfer.
  task automatic drain_and_settle();
    rx_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending_tx.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Write both registers in random order as back-to-back transfers.
  task automatic configure(input logic [31:0] id, input logic [2:0] pipe);
    logic id_first;
    id_first = $urandom_range(0, 1);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= id_first ? REG_DEVICE_ID : REG_LISTEN_PIPE;
    cfg_data_i  <= id_first ? id : 32'(pipe);
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_index_i <= id_first ? REG_LISTEN_PIPE : REG_DEVICE_ID;
    cfg_data_i  <= id_first ? 32'(pipe) : id;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    int          phase_start;
    logic [31:0] new_id;
    logic [2:0]  new_pipe;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, at the reset register values.
    rx_gap_pct   = 20;
    tx_stall_pct = 20;
    // GET with an empty payload: reports the cleared state
    start_packet(DEVICE_ID_RESET, CMD_GET, 8'd0);
    pkt_pipe = LISTEN_PIPE_RESET;
    send_packet();
    // SET to all ones: every output high, save requested
    start_packet(DEVICE_ID_RESET, CMD_SET, 8'(SET_MIN_SIZE));
    add_payload(SET_MIN_SIZE, 32'hFFFF_FFFF);
    send_packet();
    // a lone final byte is too short to carry a header
    pkt_bytes.delete();
    pkt_bytes.push_back(8'h00);
    send_packet();
    // GET on the wrong pipe is ignored
    start_packet(DEVICE_ID_RESET, CMD_GET, 8'd0);
    pkt_pipe = 3'd0;
    send_packet();

    // Random phases, each with its own register setting; the last runs without idling.
    for (int phase = 0; phase < PHASE_COUNT; phase++) begin
      drain_and_settle();
      case (phase)
        1:       begin new_id = 32'h0000_0000; new_pipe = 3'd0; end
        2:       begin new_id = 32'hFFFF_FFFF; new_pipe = 3'd5; end
        default: begin new_id = $urandom; new_pipe = 3'($urandom_range(0, 5)); end
      endcase
      configure(new_id, new_pipe);
      @(posedge clk_i);
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < BYTES_PER_PHASE) begin
        if (phase == PHASE_COUNT - 1) begin
          rx_gap_pct   = 0;
          tx_stall_pct = 0;
        end else begin
          // vary pressure per packet so quiet stretches alternate with bursty ones
          case ($urandom_range(0, 2))
            0:       rx_gap_pct = 0;
            1:       rx_gap_pct = 10;
            default: rx_gap_pct = 35;
          endcase
          case ($urandom_range(0, 2))
            0:       tx_stall_pct = 0;
            1:       tx_stall_pct = 10;
            default: tx_stall_pct = 35;
          endcase
        end
        make_random_packet();
        send_packet();
      end
    end

    drain_and_settle();
    if (sb.fails == 0 && sb.pending_tx.size() == 0) begin
      $display("radio_switch_command_handler_top regression: pass");
    end else begin
      $display("radio_switch_command_handler_top regression: fail");
    end
    $finish;
  end

endmodule
